// ===== rtl/core/sgm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sobel gradient magnitude package
// Shared widths, register indexes, reset values and the job record that
// travels from the window front end to the magnitude back end.
// ----------------------------------------------------------------------------
`default_nettype none

package sgm_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 12;
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int ABS_W       = 10;
    localparam int SQ_W        = 2 * ABS_W;
    localparam int SUM_W       = SQ_W + 1;
    localparam int ROOT_BIT_W  = $clog2(PIX_W);
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET   = 12'd1920;
    localparam logic [CFG_W-1:0] HEIGHT_RESET  = 12'd1080;
    localparam logic [CFG_W-1:0] MIN_SIZE      = 12'd3;
    localparam logic [CFG_W-1:0] MAX_WIDTH_CFG = CFG_W'(MAX_WIDTH);

    localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [ABS_W-1:0] abs_v;
        logic [ABS_W-1:0] abs_h;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             frame_last;
    } t_job;

endpackage

`default_nettype wire

// ===== rtl/core/sgm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered, read-first data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/sgm_front.sv =====
// ----------------------------------------------------------------------------
// Sobel window front end
// Takes pixels, keeps the line stores, the 3x3 window and the raster
// position, and hands gradient jobs for interior pixels to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_front import sgm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_pix                 i_pixel_value,
    output logic                      o_push,
    output t_job                      o_job,
    input  wire logic                 i_queue_full
);

    typedef enum logic {F_IDLE, F_READ} t_fstate;

    t_fstate          r_state;
    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_pix             r_cur;
    t_pix             r_win [3][3];

    t_pix             up_rd;
    t_pix             mid_rd;
    t_pix             nw [3][3];
    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;
    logic             col_end;
    logic             row_end;
    logic             emit;
    logic             step;
    logic             accept;
    logic [ABS_W-1:0] gv_pos, gv_neg, gh_pos, gh_neg;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (step),
        .i_waddr (r_col),
        .i_wdata (mid_rd),
        .i_raddr (r_col),
        .o_rdata (up_rd)
    );

    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (step),
        .i_waddr (r_col),
        .i_wdata (r_cur),
        .i_raddr (r_col),
        .o_rdata (mid_rd)
    );

    assign o_in_stall = (r_state != F_IDLE);
    assign accept     = i_in_valid && (r_state == F_IDLE);

    always_comb begin
        w_eff = r_image_width;
        if (r_image_width < MIN_SIZE) begin
            w_eff = MIN_SIZE;
        end else if (r_image_width > MAX_WIDTH_CFG) begin
            w_eff = MAX_WIDTH_CFG;
        end
        h_eff = (r_image_height < MIN_SIZE) ? MIN_SIZE : r_image_height;
    end

    assign col_end = CFG_W'(r_col) >= (w_eff - CFG_W'(1));
    assign row_end = r_row >= (h_eff - CFG_W'(1));
    assign emit    = (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
    assign step    = (r_state == F_READ) && (!emit || !i_queue_full);

    // Window after the shift that this pixel causes.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nw[i][0] = r_win[i][1];
            nw[i][1] = r_win[i][2];
        end
        nw[0][2] = up_rd;
        nw[1][2] = mid_rd;
        nw[2][2] = r_cur;
    end

    assign gv_pos = ABS_W'(nw[0][0]) + (ABS_W'(nw[0][1]) << 1) + ABS_W'(nw[0][2]);
    assign gv_neg = ABS_W'(nw[2][0]) + (ABS_W'(nw[2][1]) << 1) + ABS_W'(nw[2][2]);
    assign gh_pos = ABS_W'(nw[0][2]) + (ABS_W'(nw[1][2]) << 1) + ABS_W'(nw[2][2]);
    assign gh_neg = ABS_W'(nw[0][0]) + (ABS_W'(nw[1][0]) << 1) + ABS_W'(nw[2][0]);

    always_comb begin
        o_job.abs_v      = (gv_pos >= gv_neg) ? (gv_pos - gv_neg) : (gv_neg - gv_pos);
        o_job.abs_h      = (gh_pos >= gh_neg) ? (gh_pos - gh_neg) : (gh_neg - gh_pos);
        o_job.column     = r_col - COL_W'(1);
        o_job.row        = r_row - ROW_W'(1);
        o_job.frame_last = col_end && row_end;
    end

    assign o_push = step && emit;

    always_comb begin
        n_col = r_col + COL_W'(1);
        n_row = r_row;
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : (r_row + ROW_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= F_IDLE;
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
            r_col          <= '0;
            r_row          <= '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_cur   <= i_pixel_value;
                        r_state <= F_READ;
                    end
                end
                F_READ: begin
                    if (step) begin
                        r_win   <= nw;
                        r_col   <= n_col;
                        r_row   <= n_row;
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sgm_queue.sv =====
// ----------------------------------------------------------------------------
// Sobel job queue
// Short register FIFO that decouples the window front end from the
// magnitude back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_queue import sgm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sgm_back.sv =====
// ----------------------------------------------------------------------------
// Sobel magnitude back end
// Squares both gradients, sums them and finds the clamped integer square
// root one result bit per cycle, then holds the result for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_back import sgm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    output logic             o_pop,
    input  wire t_job        i_job,
    input  wire logic        i_queue_empty,
    input  wire logic        i_out_stall,
    output logic             o_out_valid,
    output logic [PIX_W-1:0] o_magnitude,
    output logic [COL_W-1:0] o_column,
    output logic [ROW_W-1:0] o_row,
    output logic             o_frame_last
);

    typedef enum logic [2:0] {B_IDLE, B_SQUARE, B_SUM, B_ROOT, B_DONE} t_bstate;

    t_bstate               r_state;
    t_job                  r_job;
    logic [SQ_W-1:0]       r_sq_v;
    logic [SQ_W-1:0]       r_sq_h;
    logic [SUM_W-1:0]      r_sum;
    t_pix                  r_root;
    logic [ROOT_BIT_W-1:0] r_bit;

    t_pix               trial;
    logic [2*PIX_W-1:0] trial_sq;
    logic               fits;
    logic               over;
    logic               out_free;

    assign trial    = r_root | (PIX_W'(1) << r_bit);
    assign trial_sq = (2*PIX_W)'(trial) * (2*PIX_W)'(trial);
    assign fits     = SUM_W'(trial_sq) <= r_sum;
    // Any sum of 2^16 or more has a root of at least 256 and clamps.
    assign over     = (r_sum[SUM_W-1:2*PIX_W] != '0);
    assign out_free = !o_out_valid || !i_out_stall;
    assign o_pop    = (r_state == B_IDLE) && !i_queue_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            // In the done state the output register is reloaded instead.
            if (o_out_valid && !i_out_stall && (r_state != B_DONE)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_job   <= i_job;
                        r_state <= B_SQUARE;
                    end
                end
                B_SQUARE: begin
                    r_sq_v  <= SQ_W'(r_job.abs_v) * SQ_W'(r_job.abs_v);
                    r_sq_h  <= SQ_W'(r_job.abs_h) * SQ_W'(r_job.abs_h);
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    r_sum   <= SUM_W'(r_sq_v) + SUM_W'(r_sq_h);
                    r_root  <= '0;
                    r_bit   <= ROOT_BIT_W'(PIX_W - 1);
                    r_state <= B_ROOT;
                end
                B_ROOT: begin
                    if (over) begin
                        r_root  <= MAG_MAX;
                        r_state <= B_DONE;
                    end else begin
                        if (fits) begin
                            r_root <= trial;
                        end
                        if (r_bit == '0) begin
                            r_state <= B_DONE;
                        end else begin
                            r_bit <= r_bit - ROOT_BIT_W'(1);
                        end
                    end
                end
                B_DONE: begin
                    if (out_free) begin
                        o_out_valid  <= 1'b1;
                        o_magnitude  <= r_root;
                        o_column     <= r_job.column;
                        o_row        <= r_job.row;
                        o_frame_last <= r_job.frame_last;
                        r_state      <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sobel_gradient_magnitude.sv =====
// ----------------------------------------------------------------------------
// Sobel gradient magnitude, 3x3, streaming
// A pixel request is taken in the idle state and retired by the front end in the read
// state, which waits on a full queue when a job is due, so the input side takes no new
// request until the last one is retired. The back end's square root decides one result
// bit per cycle, and a new job is popped only once the last result is registered.
// Synchronous active-low reset clears the counters, window, queue and
// output valid and restores the default image size of 1920 by 1080.
// ----------------------------------------------------------------------------
`default_nettype none

// The block streams pixels in raster order. The front end keeps two line
// stores in RAM (the row just above and the row two above), reads both at
// the current column and shifts them with the new pixel into a 3x3 window.
// When the window is centered on an interior pixel it forms the absolute
// vertical and horizontal Sobel sums and pushes them, with the pixel's
// position and the end-of-frame flag, into a four-entry queue. Border
// pixels only update the stores and the window.
//
// The back end pops one job at a time, squares and adds the two sums and
// then runs a restoring square root that decides one result bit per cycle,
// clamping to 255 when the sum reaches 65536. The finished result sits in
// an output register until the receiver takes it, while the front end goes
// on accepting pixels until the queue fills.
//
// The line stores have no reset; an entry is always written before a result
// depends on it in normal raster use.
module sobel_gradient_magnitude import sgm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [PIX_W-1:0]     i_pixel_value,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [PIX_W-1:0]          o_magnitude,
    output logic [COL_W-1:0]          o_column,
    output logic [ROW_W-1:0]          o_row,
    output logic                      o_frame_last
);

    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;
    t_job push_job;
    t_job pop_job;

    // Window, line stores, raster position and configuration registers.
    sgm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel_value (i_pixel_value),
        .o_push        (push),
        .o_job         (push_job),
        .i_queue_full  (queue_full)
    );

    // Jobs wait here so either side can stall on its own.
    sgm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (queue_empty)
    );

    // Squares, sum, square root and the output register.
    sgm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .o_pop         (pop),
        .i_job         (pop_job),
        .i_queue_empty (queue_empty),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_magnitude   (o_magnitude),
        .o_column      (o_column),
        .o_row         (o_row),
        .o_frame_last  (o_frame_last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/sgm_checker.sv =====
// ----------------------------------------------------------------------------
// Sobel gradient magnitude port checker
// Watches the top-level ports for reset, hold and position rules.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_checker import sgm_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [PIX_W-1:0]     o_magnitude,
    input wire logic [COL_W-1:0]     o_column,
    input wire logic [ROW_W-1:0]     o_row,
    input wire logic                 o_frame_last
);

    // After reset the block takes pixels and shows no result.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall after reset");

    // A stalled result keeps its valid and its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_magnitude)
            && $stable(o_column) && $stable(o_row) && $stable(o_frame_last))
        else $error("stalled result changed");

    // Results are only given for interior pixels.
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_column != '0) && (o_row != '0))
        else $error("result on a border pixel");

    // The front end spends the cycle after a pixel on the line store access.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("pixel taken while the previous one is still in work");

endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (.*);

`default_nettype wire
